/* sv/idea_pkg.sv */
// ----------------------------------------------------------------------------
// idea_pkg
// Shared constants, state types and the mod 65537 multiply for IDEA decryption
// ----------------------------------------------------------------------------
package idea_pkg;

    localparam int ROUNDS_DEFAULT = 8;
    localparam int WORD_W         = 16;
    localparam int BLOCK_W        = 64;
    localparam int KEY_W          = 128;
    localparam int CFG_INDEX_W    = 2;
    localparam int INV_STEPS      = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd1;

    // position of a subkey within its round
    localparam logic [2:0] OP_MUL_A = 3'd0;
    localparam logic [2:0] OP_ADD_B = 3'd1;
    localparam logic [2:0] OP_ADD_C = 3'd2;
    localparam logic [2:0] OP_MUL_D = 3'd3;
    localparam logic [2:0] OP_MA_P  = 3'd4;
    localparam logic [2:0] OP_MA_T  = 3'd5;

    typedef enum logic [1:0] {
        SC_LOAD,
        SC_INV,
        SC_DONE
    } sched_state_t;

    typedef enum logic [1:0] {
        RU_IDLE,
        RU_RUN,
        RU_HOLD
    } round_state_t;

    // multiply mod 65537, the value 0 stands for 65536
    function automatic logic [WORD_W-1:0] mul16(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] p;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   hi;
        logic [WORD_W-1:0]   r;
        p  = a * b;
        lo = p[WORD_W-1:0];
        hi = p[2*WORD_W-1:WORD_W];
        if (a == '0) begin
            r = 16'd1 - b;
        end else if (b == '0) begin
            r = 16'd1 - a;
        end else begin
            r = lo - hi + {15'd0, (lo < hi)};
        end
        return r;
    endfunction

endpackage

/* sv/idea_ram.sv */
// ----------------------------------------------------------------------------
// idea_ram
// Generic simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module idea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 52
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/idea_key_sched.sv */
// ----------------------------------------------------------------------------
// idea_key_sched
// Holds the key and rebuilds the decryption subkey table after each key write
// ----------------------------------------------------------------------------
module idea_key_sched #(
    parameter int ROUNDS = idea_pkg::ROUNDS_DEFAULT,
    parameter int AW     = $clog2(6 * ROUNDS + 4)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [idea_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [idea_pkg::BLOCK_W-1:0]       cfg_wdata,
    output logic                               tab_we,
    output logic [AW-1:0]                      tab_waddr,
    output logic [idea_pkg::WORD_W-1:0]        tab_wdata,
    output logic                               sched_ready
);

    localparam logic [3:0] LAST_ROUND = 4'(ROUNDS);

    idea_pkg::sched_state_t state_reg, state_next;
    logic [idea_pkg::KEY_W-1:0]  key_reg;
    logic [3:0]                  r_reg;
    logic [2:0]                  m_reg;
    logic [AW-1:0]               w_reg;
    logic [3:0]                  it_reg;
    logic [idea_pkg::WORD_W-1:0] acc_reg, base_reg;

    logic                        key_wr;
    logic [3:0]                  rr;
    logic [5:0]                  b;
    logic [5:0]                  src;
    logic                        outer;
    logic [6:0]                  ofs;
    logic [2*idea_pkg::KEY_W-1:0] rot;
    logic [idea_pkg::WORD_W-1:0] ek;
    logic                        need_inv;
    logic                        need_neg;
    logic                        last_entry;
    logic                        advance;

    assign key_wr = cfg_we && (cfg_index == idea_pkg::REG_KEY_HIGH ||
                               cfg_index == idea_pkg::REG_KEY_LOW);

    // source subkey index for the current table entry
    assign rr    = LAST_ROUND - r_reg;
    assign b     = {rr, 2'b00} + {1'b0, rr, 1'b0};
    assign outer = (r_reg == 4'd0) || (r_reg == LAST_ROUND);

    always_comb begin
        case (m_reg)
            idea_pkg::OP_MUL_A: src = b;
            idea_pkg::OP_ADD_B: src = outer ? b + 6'd1 : b + 6'd2;
            idea_pkg::OP_ADD_C: src = outer ? b + 6'd2 : b + 6'd1;
            idea_pkg::OP_MUL_D: src = b + 6'd3;
            idea_pkg::OP_MA_P:  src = b - 6'd2;
            default:            src = b - 6'd1;
        endcase
    end

    // encryption subkey: key rotated by 25 bits per group of eight words
    assign ofs = 7'({4'd0, src[5:3]} * 7'd25) + {src[2:0], 4'd0};
    assign rot = {key_reg, key_reg} << ofs;
    assign ek  = rot[2*idea_pkg::KEY_W-1 -: idea_pkg::WORD_W];

    assign need_inv   = (m_reg == idea_pkg::OP_MUL_A) || (m_reg == idea_pkg::OP_MUL_D);
    assign need_neg   = (m_reg == idea_pkg::OP_ADD_B) || (m_reg == idea_pkg::OP_ADD_C);
    assign last_entry = (r_reg == LAST_ROUND) && (m_reg == idea_pkg::OP_MUL_D);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::SC_LOAD: begin
                if (need_inv) begin
                    state_next = idea_pkg::SC_INV;
                end else if (last_entry) begin
                    state_next = idea_pkg::SC_DONE;
                end
            end
            idea_pkg::SC_INV: begin
                if (it_reg == 4'(idea_pkg::INV_STEPS - 1)) begin
                    state_next = last_entry ? idea_pkg::SC_DONE : idea_pkg::SC_LOAD;
                end
            end
            idea_pkg::SC_DONE: state_next = idea_pkg::SC_DONE;
            default:           state_next = idea_pkg::SC_LOAD;
        endcase
        if (key_wr) begin
            state_next = idea_pkg::SC_LOAD;
        end
    end

    // table write port
    always_comb begin
        tab_we    = 1'b0;
        tab_wdata = ek;
        advance   = 1'b0;
        case (state_reg)
            idea_pkg::SC_LOAD: begin
                if (!need_inv) begin
                    tab_we    = 1'b1;
                    tab_wdata = need_neg ? 16'd0 - ek : ek;
                    advance   = 1'b1;
                end
            end
            idea_pkg::SC_INV: begin
                if (it_reg == 4'(idea_pkg::INV_STEPS - 1)) begin
                    tab_we    = 1'b1;
                    tab_wdata = idea_pkg::mul16(acc_reg, base_reg);
                    advance   = 1'b1;
                end
            end
            default: begin
                tab_we = 1'b0;
            end
        endcase
        if (key_wr) begin
            tab_we  = 1'b0;
            advance = 1'b0;
        end
    end

    assign tab_waddr   = w_reg;
    assign sched_ready = (state_reg == idea_pkg::SC_DONE);

    // key, entry counters and exponentiation registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idea_pkg::SC_LOAD;
            key_reg   <= '0;
            r_reg     <= '0;
            m_reg     <= '0;
            w_reg     <= '0;
            it_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (key_wr) begin
                if (cfg_index == idea_pkg::REG_KEY_HIGH) begin
                    key_reg[idea_pkg::KEY_W-1 -: idea_pkg::BLOCK_W] <= cfg_wdata;
                end else begin
                    key_reg[idea_pkg::BLOCK_W-1:0] <= cfg_wdata;
                end
                r_reg  <= '0;
                m_reg  <= '0;
                w_reg  <= '0;
                it_reg <= '0;
            end else begin
                if (state_reg == idea_pkg::SC_INV) begin
                    it_reg <= it_reg + 4'd1;
                end else begin
                    it_reg <= '0;
                end
                if (advance) begin
                    w_reg <= w_reg + AW'(1);
                    if (m_reg == idea_pkg::OP_MA_T) begin
                        m_reg <= '0;
                        r_reg <= r_reg + 4'd1;
                    end else begin
                        m_reg <= m_reg + 3'd1;
                    end
                end
            end
        end
    end

    // a^65535 by repeated squaring, every exponent bit is one
    always_ff @(posedge aclk) begin
        if (state_reg == idea_pkg::SC_LOAD) begin
            acc_reg  <= 16'd1;
            base_reg <= ek;
        end else begin
            acc_reg  <= idea_pkg::mul16(acc_reg, base_reg);
            base_reg <= idea_pkg::mul16(base_reg, base_reg);
        end
    end

    // checks
    a_no_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == idea_pkg::SC_DONE) |-> !tab_we)
        else $error("table written after schedule finished");
    a_key_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        key_wr |=> (state_reg == idea_pkg::SC_LOAD) && (w_reg == '0))
        else $error("key write did not restart the schedule");
    a_inv_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == idea_pkg::SC_INV && it_reg != 4'd0 && !$past(key_wr))
            |-> $past(state_reg == idea_pkg::SC_INV))
        else $error("exponentiation step count broken");

endmodule

/* sv/idea_round_unit.sv */
// ----------------------------------------------------------------------------
// idea_round_unit
// Runs the rounds and output transform, one subkey from the table per cycle
// ----------------------------------------------------------------------------
module idea_round_unit #(
    parameter int ROUNDS = idea_pkg::ROUNDS_DEFAULT,
    parameter int AW     = $clog2(6 * ROUNDS + 4)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         sched_ready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [idea_pkg::BLOCK_W-1:0] s_block_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [idea_pkg::BLOCK_W-1:0] m_block_out,
    output logic [AW-1:0]                tab_raddr,
    input  logic [idea_pkg::WORD_W-1:0]  tab_rdata
);

    localparam int NK = 6 * ROUNDS + 4;
    localparam int CW = $clog2(NK + 1);
    localparam logic [CW-1:0] NK_C    = CW'(NK);
    localparam logic [CW-1:0] TRANS_C = CW'(6 * ROUNDS);

    idea_pkg::round_state_t state_reg, state_next;
    logic [CW-1:0]               iss_reg;
    logic [2:0]                  iss_m_reg;
    logic                        v_reg;
    logic [2:0]                  m_reg;
    logic                        tr_reg;
    logic [idea_pkg::WORD_W-1:0] x0_reg, x1_reg, x2_reg, x3_reg, p_reg;
    logic                        out_valid_reg;
    logic [idea_pkg::BLOCK_W-1:0] out_reg;

    logic                        accept;
    logic                        issue;
    logic                        last_op;
    logic                        out_load;
    logic [idea_pkg::WORD_W-1:0] q, t, u;

    assign accept  = s_valid && s_ready;
    assign last_op = v_reg && tr_reg && (m_reg == idea_pkg::OP_MUL_D);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idea_pkg::RU_IDLE: if (accept)  state_next = idea_pkg::RU_RUN;
            idea_pkg::RU_RUN:  if (last_op) state_next = idea_pkg::RU_HOLD;
            idea_pkg::RU_HOLD: if (!out_valid_reg || m_ready) state_next = idea_pkg::RU_IDLE;
            default:           state_next = idea_pkg::RU_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            idea_pkg::RU_IDLE: s_ready  = sched_ready;
            idea_pkg::RU_RUN:  issue    = (iss_reg < NK_C);
            idea_pkg::RU_HOLD: out_load = !out_valid_reg || m_ready;
            default:           s_ready  = 1'b0;
        endcase
    end

    assign tab_raddr = iss_reg[AW-1:0];

    // MA structure second half
    assign q = (x1_reg ^ x3_reg) + p_reg;
    assign t = idea_pkg::mul16(q, tab_rdata);
    assign u = p_reg + t;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= idea_pkg::RU_IDLE;
            iss_reg       <= '0;
            iss_m_reg     <= '0;
            v_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v_reg     <= issue;
            if (accept) begin
                iss_reg   <= '0;
                iss_m_reg <= '0;
            end else if (issue) begin
                iss_reg   <= iss_reg + CW'(1);
                iss_m_reg <= (iss_m_reg == idea_pkg::OP_MA_T) ? 3'd0 : iss_m_reg + 3'd1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // round datapath, one subkey per cycle
    always_ff @(posedge aclk) begin
        m_reg  <= iss_m_reg;
        tr_reg <= (iss_reg >= TRANS_C);
        if (accept) begin
            x0_reg <= s_block_in[63:48];
            x1_reg <= s_block_in[47:32];
            x2_reg <= s_block_in[31:16];
            x3_reg <= s_block_in[15:0];
        end else if (v_reg && !tr_reg) begin
            case (m_reg)
                idea_pkg::OP_MUL_A: x0_reg <= idea_pkg::mul16(x0_reg, tab_rdata);
                idea_pkg::OP_ADD_B: x1_reg <= x1_reg + tab_rdata;
                idea_pkg::OP_ADD_C: x2_reg <= x2_reg + tab_rdata;
                idea_pkg::OP_MUL_D: x3_reg <= idea_pkg::mul16(x3_reg, tab_rdata);
                idea_pkg::OP_MA_P:  p_reg  <= idea_pkg::mul16(x0_reg ^ x2_reg, tab_rdata);
                idea_pkg::OP_MA_T: begin
                    x0_reg <= x0_reg ^ t;
                    x1_reg <= x2_reg ^ t;
                    x2_reg <= x1_reg ^ u;
                    x3_reg <= x3_reg ^ u;
                end
                default: p_reg <= p_reg;
            endcase
        end else if (v_reg) begin
            // output transform, middle words swapped back at the output
            case (m_reg)
                idea_pkg::OP_MUL_A: x0_reg <= idea_pkg::mul16(x0_reg, tab_rdata);
                idea_pkg::OP_ADD_B: x2_reg <= x2_reg + tab_rdata;
                idea_pkg::OP_ADD_C: x1_reg <= x1_reg + tab_rdata;
                idea_pkg::OP_MUL_D: x3_reg <= idea_pkg::mul16(x3_reg, tab_rdata);
                default:            p_reg  <= p_reg;
            endcase
        end
        if (out_load) begin
            out_reg <= {x0_reg, x2_reg, x1_reg, x3_reg};
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_block_out = out_reg;

    // checks
    a_issue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (iss_reg < NK_C))
        else $error("subkey read past the table");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == idea_pkg::RU_IDLE) && !v_reg)
        else $error("input taken while a block is in flight");
    a_hold_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        last_op |=> (state_reg == idea_pkg::RU_HOLD))
        else $error("finished block not held for output");

endmodule

/* sv/idea_block_decrypt.sv */
// ----------------------------------------------------------------------------
// idea_block_decrypt
// IDEA block decryption with the decryption subkey table in a RAM
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_block_in  [63:0]
//  m_        out        m_valid / m_ready    m_block_out [63:0]
//  cfg_      in         cfg_we               cfg_index [1:0], cfg_wdata [63:0]
//
//  a block reads all 6*ROUNDS+4 subkeys from the table RAM in turn (one
//  read port, one subkey per cycle) and is then moved to the output register.
//  after reset and after every key write the table is rebuilt: each of the
//  2*(ROUNDS+1) inverse subkeys is found by modular squaring, each
//  other entry is written directly; no input is taken.
//  a finished block waits in the output register while the next is taken;
//  while that register is full and m_ready is low the engine holds.
// ----------------------------------------------------------------------------
module idea_block_decrypt #(
    parameter int ROUNDS = idea_pkg::ROUNDS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [idea_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [idea_pkg::BLOCK_W-1:0]     cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [idea_pkg::BLOCK_W-1:0]     s_block_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [idea_pkg::BLOCK_W-1:0]     m_block_out
);

    localparam int NK = 6 * ROUNDS + 4;
    localparam int AW = $clog2(NK);

    logic                        tab_we;
    logic [AW-1:0]               tab_waddr;
    logic [idea_pkg::WORD_W-1:0] tab_wdata;
    logic [AW-1:0]               tab_raddr;
    logic [idea_pkg::WORD_W-1:0] tab_rdata;
    logic                        sched_ready;

    // key schedule builder
    idea_key_sched #(.ROUNDS(ROUNDS), .AW(AW)) u_sched (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .tab_we      (tab_we),
        .tab_waddr   (tab_waddr),
        .tab_wdata   (tab_wdata),
        .sched_ready (sched_ready)
    );

    // decryption subkey table
    idea_ram #(.WIDTH(idea_pkg::WORD_W), .DEPTH(NK)) u_tab (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // round engine
    idea_round_unit #(.ROUNDS(ROUNDS), .AW(AW)) u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sched_ready (sched_ready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_block_in  (s_block_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_block_out (m_block_out),
        .tab_raddr   (tab_raddr),
        .tab_rdata   (tab_rdata)
    );

endmodule

/* tb/sv/tb_idea_block_decrypt.sv */
// ----------------------------------------------------------------------------
// tb_idea_block_decrypt
// Checks IDEA block decryption against a behavioral predictor: a directed
// table of blocks, then random bursts under fixed and random keys, with random
// sender gaps and receiver stalls and in-order checking of every result.
// ----------------------------------------------------------------------------
module tb_idea_block_decrypt;

    localparam int ROUNDS    = idea_pkg::ROUNDS_DEFAULT;
    localparam int NSUB      = 6 * ROUNDS + 4;
    localparam int REBUILD   = 34 * (ROUNDS + 1) + 4 * ROUNDS + 20;
    localparam int N_DIRECT  = 12;
    localparam int N_PHASES  = 6;
    localparam int PER_PHASE = 210;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [idea_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [idea_pkg::BLOCK_W-1:0]     cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic [idea_pkg::BLOCK_W-1:0]     s_block_in;
    logic                             m_valid;
    logic                             m_ready;
    logic [idea_pkg::BLOCK_W-1:0]     m_block_out;

    // predictor state
    logic [63:0] key_hi_q, key_lo_q;
    logic [15:0] dk [0:51];

    logic [63:0] plain_q [$];
    int          errors;
    bit          rx_stall_mode;

    // directed table: block, expected, whether expected is typed in
    typedef struct {
        logic [63:0] blk;
        logic [63:0] exp_blk;
        bit          fixed;
    } dir_row_t;
    dir_row_t dir_tab [N_DIRECT];

    idea_block_decrypt #(.ROUNDS(ROUNDS)) DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("Test completed with failures");
        $finish;
    end

    // mod 65537 multiply, 0 stands for 65536
    function automatic logic [15:0] mmul(logic [15:0] a, logic [15:0] b);
        logic [32:0] x, y;
        x = (a == 0) ? 33'd65536 : {17'd0, a};
        y = (b == 0) ? 33'd65536 : {17'd0, b};
        return 16'(((x * y) % 65537));
    endfunction

    function automatic logic [15:0] minv(logic [15:0] a);
        logic [33:0] base, acc;
        int          e;
        base = (a == 0) ? 34'd65536 : {18'd0, a};
        acc  = 34'd1;
        e    = 65535;
        while (e != 0) begin
            if (e & 1) acc = (acc * base) % 65537;
            base = (base * base) % 65537;
            e = e >> 1;
        end
        return acc[15:0];
    endfunction

    // decryption schedule from the current key
    task automatic rebuild_table();
        logic [15:0]  ek [0:51];
        logic [127:0] kk;
        int           b;
        kk = {key_hi_q, key_lo_q};
        for (int i = 0; i < 52; i++) begin
            if (i > 0 && i % 8 == 0) kk = {kk[102:0], kk[127:103]};
            ek[i] = kk[127 - 16 * (i % 8) -: 16];
        end
        for (int i = 0; i < 52; i++) dk[i] = '0;
        for (int r = 0; r <= ROUNDS; r++) begin
            b = 6 * (ROUNDS - r);
            dk[6*r]   = minv(ek[b]);
            dk[6*r+3] = minv(ek[b+3]);
            if (r == 0 || r == ROUNDS) begin
                dk[6*r+1] = 16'(-ek[b+1]);
                dk[6*r+2] = 16'(-ek[b+2]);
            end else begin
                dk[6*r+1] = 16'(-ek[b+2]);
                dk[6*r+2] = 16'(-ek[b+1]);
            end
            if (r < ROUNDS) begin
                dk[6*r+4] = ek[b-2];
                dk[6*r+5] = ek[b-1];
            end
        end
    endtask

    function automatic logic [63:0] decrypt_block(logic [63:0] blk);
        logic [15:0] x0, x1, x2, x3, a, b, c, d, p, q, t, u;
        int          o;
        {x0, x1, x2, x3} = blk;
        for (int r = 0; r < ROUNDS; r++) begin
            o = 6 * r;
            a = mmul(x0, dk[o]);
            b = x1 + dk[o+1];
            c = x2 + dk[o+2];
            d = mmul(x3, dk[o+3]);
            p = mmul(a ^ c, dk[o+4]);
            q = (b ^ d) + p;
            t = mmul(q, dk[o+5]);
            u = p + t;
            x0 = a ^ t;
            x1 = c ^ t;
            x2 = b ^ u;
            x3 = d ^ u;
        end
        o = 6 * ROUNDS;
        return {mmul(x0, dk[o]), 16'(x2 + dk[o+1]), 16'(x1 + dk[o+2]),
                mmul(x3, dk[o+3])};
    endfunction

    // register write while idle, then wait out the table rebuild
    task automatic write_key(logic [idea_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == idea_pkg::REG_KEY_HIGH) key_hi_q = val;
        else if (idx == idea_pkg::REG_KEY_LOW) key_lo_q = val;
        rebuild_table();
        repeat (REBUILD) @(posedge aclk);
    endtask

    // send one block and queue its expected plaintext; valid is left high
    task automatic send_block(logic [63:0] blk, logic [63:0] exp_blk);
        s_valid    <= 1'b1;
        s_block_in <= blk;
        do @(posedge aclk); while (!s_ready);
        plain_q.push_back(exp_blk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (plain_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4 * NSUB) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver: stall pattern switches between none and heavy
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_stall_mode = ~rx_stall_mode;
            m_ready <= rx_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (plain_q.size() == 0) begin
                $display("%0t: block_out expected none actual %h", $time, m_block_out);
                errors++;
            end else begin
                want = plain_q.pop_front();
                if (m_block_out !== want) begin
                    $display("%0t: block_out expected %h actual %h",
                             $time, want, m_block_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        int          burst;
        logic [63:0] blk;
        errors        = 0;
        rx_stall_mode = 1'b0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_block_in    = '0;
        key_hi_q      = '0;
        key_lo_q      = '0;
        rebuild_table();

        // all-zero key: every subkey is 0, which stands for 65536
        dir_tab[0]  = '{64'h0, 64'h0, 1'b0};
        dir_tab[1]  = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0};
        dir_tab[2]  = '{64'h0001_0001_0001_0001, 64'h0, 1'b0};
        dir_tab[3]  = '{64'h8000_0000_0000_8000, 64'h0, 1'b0};
        dir_tab[4]  = '{64'h0123_4567_89AB_CDEF, 64'h0, 1'b0};
        dir_tab[5]  = '{64'hFFFF_0000_FFFF_0000, 64'h0, 1'b0};
        dir_tab[6]  = '{64'h0000_FFFF_0000_FFFF, 64'h0, 1'b0};
        dir_tab[7]  = '{64'h5555_AAAA_5555_AAAA, 64'h0, 1'b0};
        dir_tab[8]  = '{64'hAAAA_5555_AAAA_5555, 64'h0, 1'b0};
        dir_tab[9]  = '{64'h7FFF_8000_0001_FFFE, 64'h0, 1'b0};
        dir_tab[10] = '{64'hDEAD_BEEF_0BAD_F00D, 64'h0, 1'b0};
        dir_tab[11] = '{64'h0000_0001_0000_0000, 64'h0, 1'b0};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (REBUILD) @(posedge aclk);

        // directed blocks under the reset key
        for (int i = 0; i < N_DIRECT; i++) begin
            send_block(dir_tab[i].blk, dir_tab[i].fixed ? dir_tab[i].exp_blk
                                                        : decrypt_block(dir_tab[i].blk));
        end
        s_valid <= 1'b0;
        drain();

        // key extremes, stray register indexes, then random keys
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_key(idea_pkg::REG_KEY_HIGH, '1);
                    write_key(idea_pkg::REG_KEY_LOW, '1);
                end
                1: begin
                    write_key(idea_pkg::REG_KEY_HIGH, 64'h0);
                    write_key(idea_pkg::REG_KEY_LOW, 64'h0000_0000_0000_0001);
                end
                2: begin
                    write_key(idea_pkg::REG_KEY_HIGH, 64'h0001_0002_0003_0004);
                    write_key(idea_pkg::REG_KEY_LOW, 64'h0005_0006_0007_0008);
                    write_key(idea_pkg::CFG_INDEX_W'(2), rand64());
                    write_key(idea_pkg::CFG_INDEX_W'(3), rand64());
                end
                default: begin
                    write_key(idea_pkg::REG_KEY_HIGH, rand64());
                    write_key(idea_pkg::REG_KEY_LOW, rand64());
                end
            endcase
            for (int n = 0; n < PER_PHASE; ) begin
                burst = $urandom_range(1, 12);
                for (int j = 0; j < burst && n < PER_PHASE; j++, n++) begin
                    case ($urandom_range(0, 7))
                        0:       blk = {4{16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0)}};
                        1:       blk = rand64() & rand64();
                        2:       blk = rand64() | rand64();
                        default: blk = rand64();
                    endcase
                    send_block(blk, decrypt_block(blk));
                end
                // gap between bursts
                if ($urandom_range(0, 2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end
            end
            s_valid <= 1'b0;
            drain();
        end

        if (errors == 0 && plain_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
